// ===== hdl/rsp16_pkg.sv =====
// shared constants, register indexes and helpers for the rgb shade-and-pack block
`default_nettype none

package rsp16_pkg;

  // colour and packing widths
  localparam int unsigned ChanW  = 8;
  localparam int unsigned PixW   = 16;
  localparam int unsigned ScaleW = 10;
  localparam int unsigned FmtW   = 21;
  localparam int unsigned ShW    = 5;
  localparam int unsigned IdxW   = 3;

  // luminance weights and divisor
  localparam int unsigned LumaR   = 299;
  localparam int unsigned LumaG   = 587;
  localparam int unsigned LumaB   = 114;
  localparam int unsigned LumaDiv = 1000;
  localparam int unsigned WtW     = 10;
  localparam int unsigned SumW    = 18;

  // reciprocal of the luminance divisor, exact for every weighted sum below 2^SumW
  localparam int unsigned RecipShift = SumW + 10;
  localparam int unsigned RecipW     = 19;
  localparam logic [RecipW-1:0] LumaRecip =
    RecipW'(((64'd1 << RecipShift) + LumaDiv - 1) / LumaDiv);
  localparam int unsigned RecipProdW = SumW + RecipW;

  // scaling
  localparam int unsigned ScaleShift = 8;
  localparam int unsigned ScaledW    = ChanW + ScaleW;
  localparam logic [ChanW-1:0] ChanMax  = 8'd255;
  localparam logic [PixW-1:0]  BlackSub = 16'h0001;

  // reset values
  localparam logic [ScaleW-1:0] ScaleUnity = 10'd256;
  localparam logic [FmtW-1:0]   FmtReset   = '0;

  // configuration register indexes
  localparam logic [IdxW-1:0] RegRedScale   = 3'd0;
  localparam logic [IdxW-1:0] RegGreenScale = 3'd1;
  localparam logic [IdxW-1:0] RegBlueScale  = 3'd2;
  localparam logic [IdxW-1:0] RegMonoMode   = 3'd3;
  localparam logic [IdxW-1:0] RegRedFmt     = 3'd4;
  localparam logic [IdxW-1:0] RegGreenFmt   = 3'd5;
  localparam logic [IdxW-1:0] RegBlueFmt    = 3'd6;

  // shift one clamped channel into place and apply its mask
  function automatic logic [PixW-1:0] place_channel(input logic [ChanW-1:0] c,
                                                    input logic [FmtW-1:0] fmt);
    logic [ShW-1:0]  sh;
    logic [ShW-1:0]  amount;
    logic [PixW-1:0] wide;
    logic [PixW-1:0] v;
    sh     = fmt[FmtW-1:PixW];
    amount = ShW'(0) - sh;
    wide   = {{(PixW-ChanW){1'b0}}, c};
    if (sh[ShW-1]) begin
      // right shift, anything of eight or more clears the channel
      if (amount >= ShW'(ChanW)) begin
        v = '0;
      end else begin
        v = wide >> amount[2:0];
      end
    end else begin
      // left shift, bits above the top are dropped
      v = wide << sh[ShW-2:0];
    end
    return v & fmt[PixW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rgb_shade_and_pack_16bit_top.sv =====
// rgb888 to 16-bit packed pixel converter with optional luminance shading
`default_nettype none

// Converts one 8-bit RGB colour per clock into a 16-bit packed pixel. A colour
// is taken at each clock edge where start is high (busy is always low), and its
// pixel later appears on packed_pixel with done high for one cycle.
// The pipeline has four register stages: weighted luminance sum, reciprocal
// multiply for the divide by 1000, per-channel scale and clamp, then shift,
// mask and pack. Results cannot be held off, so the pipeline never stalls.
// Configuration writes take effect at once and belong in idle periods.
module rgb_shade_and_pack_16bit_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [rsp16_pkg::ChanW-1:0]   red_in,
  input  wire logic [rsp16_pkg::ChanW-1:0]   green_in,
  input  wire logic [rsp16_pkg::ChanW-1:0]   blue_in,
  input  wire logic                          wr_en,
  input  wire logic [rsp16_pkg::IdxW-1:0]    wr_index,
  input  wire logic [rsp16_pkg::FmtW-1:0]    wr_data,
  output logic                               done,
  output logic [rsp16_pkg::PixW-1:0]         packed_pixel
);

  localparam int unsigned CW = rsp16_pkg::ChanW;

  // configuration registers
  logic [rsp16_pkg::ScaleW-1:0] red_scale, green_scale, blue_scale;
  logic                         mono_mode;
  logic [rsp16_pkg::FmtW-1:0]   red_format, green_format, blue_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_scale    <= rsp16_pkg::ScaleUnity;
      green_scale  <= rsp16_pkg::ScaleUnity;
      blue_scale   <= rsp16_pkg::ScaleUnity;
      mono_mode    <= 1'b0;
      red_format   <= rsp16_pkg::FmtReset;
      green_format <= rsp16_pkg::FmtReset;
      blue_format  <= rsp16_pkg::FmtReset;
    end else if (wr_en) begin
      unique case (wr_index)
        rsp16_pkg::RegRedScale:   red_scale    <= wr_data[rsp16_pkg::ScaleW-1:0];
        rsp16_pkg::RegGreenScale: green_scale  <= wr_data[rsp16_pkg::ScaleW-1:0];
        rsp16_pkg::RegBlueScale:  blue_scale   <= wr_data[rsp16_pkg::ScaleW-1:0];
        rsp16_pkg::RegMonoMode:   mono_mode    <= wr_data[0];
        rsp16_pkg::RegRedFmt:     red_format   <= wr_data;
        rsp16_pkg::RegGreenFmt:   green_format <= wr_data;
        rsp16_pkg::RegBlueFmt:    blue_format  <= wr_data;
        default: ;
      endcase
    end
  end

  // the pipeline always advances
  assign busy = 1'b0;

  // stage 1: weighted luminance sum
  logic                           s1_valid;
  logic [CW-1:0]                  s1_r, s1_g, s1_b;
  logic [rsp16_pkg::SumW-1:0]     s1_sum;
  logic [rsp16_pkg::SumW-1:0]     sum_next;

  always_comb begin
    sum_next = rsp16_pkg::SumW'(red_in)   * rsp16_pkg::SumW'(rsp16_pkg::LumaR)
             + rsp16_pkg::SumW'(green_in) * rsp16_pkg::SumW'(rsp16_pkg::LumaG)
             + rsp16_pkg::SumW'(blue_in)  * rsp16_pkg::SumW'(rsp16_pkg::LumaB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    s1_r   <= red_in;
    s1_g   <= green_in;
    s1_b   <= blue_in;
    s1_sum <= sum_next;
  end

  // stage 2: divide by 1000 through the reciprocal product
  logic                              s2_valid;
  logic [CW-1:0]                     s2_r, s2_g, s2_b;
  logic [rsp16_pkg::RecipProdW-1:0]  s2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_r    <= s1_r;
    s2_g    <= s1_g;
    s2_b    <= s1_b;
    s2_prod <= rsp16_pkg::RecipProdW'(s1_sum) * rsp16_pkg::RecipProdW'(rsp16_pkg::LumaRecip);
  end

  // stage 3: pick channel or luminance, scale and clamp
  logic [CW-1:0]                  lum;
  logic [CW-1:0]                  src_r, src_g, src_b;
  logic [rsp16_pkg::ScaledW-1:0]  sc_r, sc_g, sc_b;
  logic [CW-1:0]                  clamp_r, clamp_g, clamp_b;
  logic                           s3_valid;
  logic [CW-1:0]                  s3_r, s3_g, s3_b;

  always_comb begin
    lum   = s2_prod[rsp16_pkg::RecipShift +: CW];
    src_r = mono_mode ? lum : s2_r;
    src_g = mono_mode ? lum : s2_g;
    src_b = mono_mode ? lum : s2_b;
    sc_r  = (rsp16_pkg::ScaledW'(src_r) * rsp16_pkg::ScaledW'(red_scale))
            >> rsp16_pkg::ScaleShift;
    sc_g  = (rsp16_pkg::ScaledW'(src_g) * rsp16_pkg::ScaledW'(green_scale))
            >> rsp16_pkg::ScaleShift;
    sc_b  = (rsp16_pkg::ScaledW'(src_b) * rsp16_pkg::ScaledW'(blue_scale))
            >> rsp16_pkg::ScaleShift;
    clamp_r = (sc_r > rsp16_pkg::ScaledW'(rsp16_pkg::ChanMax)) ? rsp16_pkg::ChanMax
                                                               : sc_r[CW-1:0];
    clamp_g = (sc_g > rsp16_pkg::ScaledW'(rsp16_pkg::ChanMax)) ? rsp16_pkg::ChanMax
                                                               : sc_g[CW-1:0];
    clamp_b = (sc_b > rsp16_pkg::ScaledW'(rsp16_pkg::ChanMax)) ? rsp16_pkg::ChanMax
                                                               : sc_b[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_r <= clamp_r;
    s3_g <= clamp_g;
    s3_b <= clamp_b;
  end

  // stage 4: shift, mask, merge and black substitute
  logic [rsp16_pkg::PixW-1:0] px;
  logic [rsp16_pkg::PixW-1:0] px_next;

  always_comb begin
    px = rsp16_pkg::place_channel(s3_r, red_format)
       | rsp16_pkg::place_channel(s3_g, green_format)
       | rsp16_pkg::place_channel(s3_b, blue_format);
    if (px == '0 && (s3_r | s3_g | s3_b) != '0) begin
      px_next = rsp16_pkg::BlackSub;
    end else begin
      px_next = px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_valid;
    end
    packed_pixel <= px_next;
  end

endmodule

`default_nettype wire
